// ----- rtl/steering_accel_seek_arrive_flee_top_defines.svh -----
// Assertion helpers shared by the steering pipeline files.
`ifndef STEERING_ACCEL_SEEK_ARRIVE_FLEE_TOP_DEFINES_SVH
`define STEERING_ACCEL_SEEK_ARRIVE_FLEE_TOP_DEFINES_SVH

// Same-cycle implication, held off while reset is low
`define SASF_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("steering pipeline check failed");

// Next-cycle implication, held off while reset is low
`define SASF_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("steering pipeline check failed");

`endif

// ----- rtl/sasf_pkg.sv -----
package sasf_pkg;

  // Component and working widths
  localparam int COMP_W  = 32;
  localparam int MAG_W   = 31;
  localparam int LEN_W   = 32;
  localparam int SUMSQ_W = 64;
  localparam int FRAC_W  = 16;
  localparam int CFG_W   = 31;
  localparam int IDX_W   = 3;

  typedef enum logic [1:0] {
    MODE_SEEK   = 2'd0,
    MODE_ARRIVE = 2'd1,
    MODE_FLEE   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  // Register indexes on the configuration port
  localparam logic [IDX_W-1:0] REG_MODE        = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_ACCEL   = 3'd1;
  localparam logic [IDX_W-1:0] REG_MAX_SPEED   = 3'd2;
  localparam logic [IDX_W-1:0] REG_SLOW_RADIUS = 3'd3;
  localparam logic [IDX_W-1:0] REG_ATTENUATION = 3'd4;

  // Reset values
  localparam logic [CFG_W-1:0] RST_MAX_ACCEL   = 31'd65536;
  localparam logic [CFG_W-1:0] RST_MAX_SPEED   = 31'd65536;
  localparam logic [CFG_W-1:0] RST_SLOW_RADIUS = 31'd655360;
  localparam logic [CFG_W-1:0] RST_ATTENUATION = 31'd65536;

endpackage

// ----- rtl/sasf_udiv.sv -----
// Pipelined restoring divider, one quotient bit per stage, shared divisor
// for all lanes. The quotient must fit in QW bits for the result to hold.
module sasf_udiv #(
  parameter int LANES = 3,
  parameter int NW    = 62,
  parameter int DW    = 32,
  parameter int QW    = 31,
  parameter int SW    = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       vld_i,
  input  logic [LANES-1:0][NW-1:0]   num_i,
  input  logic [DW-1:0]              den_i,
  input  logic [SW-1:0]              side_i,
  output logic                       vld_o,
  output logic [LANES-1:0][QW-1:0]   quo_o,
  output logic [SW-1:0]              side_o
);
  localparam int RW = DW + 1;

  logic                      v_r    [0:QW];
  logic [LANES-1:0][RW-1:0]  rem_r  [0:QW-1];
  logic [LANES-1:0][QW-1:0]  lo_r   [0:QW];
  logic [DW-1:0]             den_r  [0:QW-1];
  logic [SW-1:0]             side_r [0:QW];

  // Input stage: high dividend bits preload the partial remainder
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        rem_r[0][l] <= RW'(num_i[l] >> QW);
        lo_r[0][l]  <= num_i[l][QW-1:0];
      end
      den_r[0]  <= den_i;
      side_r[0] <= side_i;
    end
  end

  // One quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [LANES-1:0][RW-1:0] rem2;
    logic [LANES-1:0][RW-1:0] rem_nxt;
    logic [LANES-1:0]         ge;

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rem2[l]    = {rem_r[j][l][RW-2:0], lo_r[j][l][QW-1]};
        ge[l]      = rem2[l] >= {1'b0, den_r[j]};
        rem_nxt[l] = ge[l] ? rem2[l] - {1'b0, den_r[j]} : rem2[l];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[j+1] <= 1'b0;
      end else if (en) begin
        v_r[j+1] <= v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < LANES; l++) begin
          lo_r[j+1][l] <= {lo_r[j][l][QW-2:0], ge[l]};
        end
        side_r[j+1] <= side_r[j];
      end
    end

    if (j < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j+1] <= rem_nxt;
          den_r[j+1] <= den_r[j];
        end
      end
    end
  end

  assign vld_o  = v_r[QW];
  assign quo_o  = lo_r[QW];
  assign side_o = side_r[QW];

endmodule

// ----- rtl/sasf_vlen.sv -----
`include "steering_accel_seek_arrive_flee_top_defines.svh"
// Vector length unit: magnitudes, range shift, sum of squares, then a
// pipelined integer square root, one root bit per stage.
module sasf_vlen #(
  parameter int VW = 34,
  parameter int SW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                vld_i,
  input  logic [2:0][VW-1:0]  vec_i,
  input  logic [SW-1:0]       side_i,
  output logic                vld_o,
  output logic [2:0][30:0]    mag_o,
  output logic [2:0]          neg_o,
  output logic                scaled_o,
  output logic [63:0]         sumsq_o,
  output logic [31:0]         len_o,
  output logic [SW-1:0]       side_o
);
  import sasf_pkg::*;

  localparam int SHW = $clog2(VW - MAG_W + 2);

  typedef struct packed {
    logic [2:0][MAG_W-1:0] mag;
    logic [2:0]            neg;
    logic                  sc;
    logic [SUMSQ_W-1:0]    sumsq;
    logic [SW-1:0]         side;
  } vl_pl_t;

  // Stage 1: magnitudes and their OR
  logic                 v1_r;
  logic [2:0][VW-1:0]   mag1_r;
  logic [2:0]           neg1_r;
  logic [VW-1:0]        orm1_r;
  logic [SW-1:0]        side1_r;
  logic [2:0][VW-1:0]   mag1_nxt;
  logic [2:0]           neg1_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg1_nxt[i] = vec_i[i][VW-1];
      mag1_nxt[i] = neg1_nxt[i] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
  end

  // Stage 2: shift so the largest magnitude fits 31 bits
  logic                  v2_r;
  logic [2:0][MAG_W-1:0] mag2_r;
  logic [2:0]            neg2_r;
  logic                  sc2_r;
  logic [SW-1:0]         side2_r;
  logic [SHW-1:0]        sh;

  always_comb begin
    sh = '0;
    for (int k = MAG_W; k < VW; k++) begin
      if (orm1_r[k]) sh = SHW'(k - (MAG_W - 1));
    end
  end

  // Stage 3: squares; stage 4: their sum
  logic                    v3_r;
  logic [2:0][MAG_W-1:0]   mag3_r;
  logic [2:0]              neg3_r;
  logic                    sc3_r;
  logic [SW-1:0]           side3_r;
  logic [2:0][2*MAG_W-1:0] sq3_r;

  logic         sq_v_r    [0:32];
  logic [35:0]  sq_rem_r  [0:31];
  logic [31:0]  sq_root_r [0:32];
  vl_pl_t       sq_pl_r   [0:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      sq_v_r[0]  <= 1'b0;
    end else if (en) begin
      v1_r       <= vld_i;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      sq_v_r[0]  <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1_r  <= mag1_nxt;
      neg1_r  <= neg1_nxt;
      orm1_r  <= mag1_nxt[0] | mag1_nxt[1] | mag1_nxt[2];
      side1_r <= side_i;
      for (int i = 0; i < 3; i++) begin
        mag2_r[i] <= MAG_W'(mag1_r[i] >> sh);
      end
      neg2_r  <= neg1_r;
      sc2_r   <= |orm1_r[VW-1:MAG_W];
      side2_r <= side1_r;
      for (int i = 0; i < 3; i++) begin
        sq3_r[i] <= (2*MAG_W)'(mag2_r[i]) * (2*MAG_W)'(mag2_r[i]);
      end
      mag3_r  <= mag2_r;
      neg3_r  <= neg2_r;
      sc3_r   <= sc2_r;
      side3_r <= side2_r;
      sq_pl_r[0].mag   <= mag3_r;
      sq_pl_r[0].neg   <= neg3_r;
      sq_pl_r[0].sc    <= sc3_r;
      sq_pl_r[0].sumsq <= SUMSQ_W'(sq3_r[0]) + SUMSQ_W'(sq3_r[1]) + SUMSQ_W'(sq3_r[2]);
      sq_pl_r[0].side  <= side3_r;
      sq_rem_r[0]      <= '0;
      sq_root_r[0]     <= '0;
    end
  end

  // Square root: two radicand bits in, one root bit out per stage
  for (genvar j = 0; j < 32; j++) begin : g_sqrt
    logic [35:0] rem2;
    logic [35:0] trial;
    logic        ge;

    always_comb begin
      rem2  = {sq_rem_r[j][33:0], sq_pl_r[j].sumsq[SUMSQ_W-1-2*j -: 2]};
      trial = {2'b00, sq_root_r[j], 2'b01};
      ge    = rem2 >= trial;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_v_r[j+1] <= 1'b0;
      end else if (en) begin
        sq_v_r[j+1] <= sq_v_r[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_root_r[j+1] <= {sq_root_r[j][30:0], ge};
        sq_pl_r[j+1]   <= sq_pl_r[j];
      end
    end

    if (j < 31) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          sq_rem_r[j+1] <= ge ? rem2 - trial : rem2;
        end
      end
    end
  end

  assign vld_o    = sq_v_r[32];
  assign mag_o    = sq_pl_r[32].mag;
  assign neg_o    = sq_pl_r[32].neg;
  assign scaled_o = sq_pl_r[32].sc;
  assign sumsq_o  = sq_pl_r[32].sumsq;
  assign len_o    = sq_root_r[32];
  assign side_o   = sq_pl_r[32].side;

  // Root is the floor of the square root
  `SASF_ASSERT_IMPL(a_len_low, clk, rst_n, vld_o, 64'(len_o) * 64'(len_o) <= sumsq_o)
  `SASF_ASSERT_IMPL(a_len_high, clk, rst_n, vld_o, (66'(len_o) + 66'd1) * (66'(len_o) + 66'd1) > 66'(sumsq_o))

endmodule

// ----- rtl/steering_accel_seek_arrive_flee_top.sv -----
// Steering acceleration pipeline: one agent item (position, velocity, goal as
// signed Q16.16 vectors) may enter every clock and acceleration items leave in
// order. The pipeline is a chain of bit-per-stage units: two 32-stage square
// roots, three 31-stage dividers and one 48-stage divider for the attenuation,
// plus register stages for subtraction, squaring and scaling. Throughput is one
// item per cycle; the whole pipeline holds while the output register waits to
// be taken. Mode and limits come from the configuration registers, which are to
// be written only while the pipeline is empty; the block does not enforce this.
`include "steering_accel_seek_arrive_flee_top_defines.svh"
module steering_accel_seek_arrive_flee_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, goal_x, goal_y, goal_z
  input  logic [287:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // accel_x, accel_y, accel_z
  output logic [95:0]   out_tdata,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [30:0]   cfg_wdata
);
  import sasf_pkg::*;

  typedef struct packed {
    logic [2:0][MAG_W-1:0]  mag;
    logic [2:0]             neg;
    logic                   clamp;
    logic                   usemax;
    logic                   lenz;
    logic [LEN_W-1:0]       len;
    logic [2:0][COMP_W-1:0] vel;
  } p1_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0]  mag;
    logic [2:0]             neg;
    logic                   clamp;
    logic                   lenz;
    logic [2:0][COMP_W-1:0] vel;
  } p2_t;

  typedef struct packed {
    logic [2:0][COMP_W-1:0] res;
    logic [2:0]             nege;
  } p3_t;

  typedef struct packed {
    logic [2:0][MAG_W-1:0]  mag;
    logic [2:0]             neg;
    logic                   clamp;
    logic                   lenz;
    logic [2:0][COMP_W-1:0] res;
  } p5_t;

  // Configuration registers
  mode_t              mode_r;
  logic [CFG_W-1:0]   max_accel_r;
  logic [CFG_W-1:0]   max_speed_r;
  logic [CFG_W-1:0]   slow_radius_r;
  logic [CFG_W-1:0]   attn_r;
  logic [2*CFG_W-1:0] ma_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_SEEK;
      max_accel_r   <= RST_MAX_ACCEL;
      max_speed_r   <= RST_MAX_SPEED;
      slow_radius_r <= RST_SLOW_RADIUS;
      attn_r        <= RST_ATTENUATION;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MODE:        mode_r        <= mode_t'(cfg_wdata[1:0]);
        REG_MAX_ACCEL:   max_accel_r   <= cfg_wdata;
        REG_MAX_SPEED:   max_speed_r   <= cfg_wdata;
        REG_SLOW_RADIUS: slow_radius_r <= cfg_wdata;
        REG_ATTENUATION: attn_r        <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Squared clamp limit, follows max_accel
  always_ff @(posedge clk) begin
    ma_sq_r <= (2*CFG_W)'(max_accel_r) * (2*CFG_W)'(max_accel_r);
  end

  // Global advance: the pipeline moves when the output register is free
  logic en;
  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Stage 0: first vector (goal - pos, the flee vector, or zero)
  logic                          p0_v_r;
  logic [2:0][33:0]              p0_w_r;
  logic [2:0][COMP_W-1:0]        p0_vel_r;
  logic [2:0][33:0]              p0_w_nxt;
  logic signed [2:0][33:0]       dg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dg[i] = 34'($signed(in_tdata[192+32*i +: 32])) - 34'($signed(in_tdata[32*i +: 32]));
    end
    unique case (mode_r)
      MODE_SEEK, MODE_ARRIVE: p0_w_nxt = dg;
      // e = pos - goal; f = (ex - ez, ey, ez + ex)
      MODE_FLEE: begin
        p0_w_nxt[0] = dg[2] - dg[0];
        p0_w_nxt[1] = -dg[1];
        p0_w_nxt[2] = -dg[2] - dg[0];
      end
      MODE_NONE: p0_w_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p0_v_r <= 1'b0;
    end else if (en) begin
      p0_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0_w_r <= p0_w_nxt;
      for (int i = 0; i < 3; i++) p0_vel_r[i] <= in_tdata[96+32*i +: 32];
    end
  end

  // First length
  logic                   l1_v;
  logic [2:0][MAG_W-1:0]  l1_mag;
  logic [2:0]             l1_neg;
  logic                   l1_sc;
  logic [SUMSQ_W-1:0]     l1_sumsq;
  logic [LEN_W-1:0]       l1_len;
  logic [2:0][COMP_W-1:0] l1_vel;

  sasf_vlen #(.VW(34), .SW(3*COMP_W)) u_len1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(p0_v_r), .vec_i(p0_w_r), .side_i(p0_vel_r),
    .vld_o(l1_v), .mag_o(l1_mag), .neg_o(l1_neg), .scaled_o(l1_sc),
    .sumsq_o(l1_sumsq), .len_o(l1_len), .side_o(l1_vel)
  );

  // Stage 1: arrive speed product and clamp decision
  logic               p1_v_r;
  p1_t                p1_side_r;
  logic [61:0]        p1_prod_r;
  p1_t                p1_side_nxt;

  always_comb begin
    p1_side_nxt.mag    = l1_mag;
    p1_side_nxt.neg    = l1_neg;
    p1_side_nxt.clamp  = l1_sc || (l1_sumsq > SUMSQ_W'(ma_sq_r));
    p1_side_nxt.usemax = l1_sc || (l1_len >= {1'b0, slow_radius_r});
    p1_side_nxt.lenz   = (l1_len == '0);
    p1_side_nxt.len    = l1_len;
    p1_side_nxt.vel    = l1_vel;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= l1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_side_r <= p1_side_nxt;
      p1_prod_r <= 62'(l1_len[MAG_W-1:0]) * 62'(max_speed_r);
    end
  end

  // Arrive speed inside the slow radius
  logic                  d1_v;
  logic [0:0][MAG_W-1:0] d1_q;
  p1_t                   d1_side;

  sasf_udiv #(.LANES(1), .NW(62), .DW(CFG_W), .QW(MAG_W), .SW($bits(p1_t))) u_div_speed (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(p1_v_r), .num_i(p1_prod_r), .den_i(slow_radius_r), .side_i(p1_side_r),
    .vld_o(d1_v), .quo_o(d1_q), .side_o(d1_side)
  );

  // Stage 2: rescale numerators
  logic              p2_v_r;
  logic [2:0][61:0]  p2_num_r;
  logic [LEN_W-1:0]  p2_den_r;
  p2_t               p2_side_r;
  logic [CFG_W-1:0]  tgt1;

  always_comb begin
    if (mode_r == MODE_ARRIVE) begin
      tgt1 = d1_side.usemax ? max_speed_r : d1_q[0];
    end else begin
      tgt1 = max_accel_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (en) begin
      p2_v_r <= d1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) p2_num_r[i] <= 62'(d1_side.mag[i]) * 62'(tgt1);
      p2_den_r        <= d1_side.len;
      p2_side_r.mag   <= d1_side.mag;
      p2_side_r.neg   <= d1_side.neg;
      p2_side_r.clamp <= d1_side.clamp;
      p2_side_r.lenz  <= d1_side.lenz;
      p2_side_r.vel   <= d1_side.vel;
    end
  end

  logic                  d2_v;
  logic [2:0][MAG_W-1:0] d2_q;
  p2_t                   d2_side;

  sasf_udiv #(.LANES(3), .NW(62), .DW(LEN_W), .QW(MAG_W), .SW($bits(p2_t))) u_div_rescale1 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(p2_v_r), .num_i(p2_num_r), .den_i(p2_den_r), .side_i(p2_side_r),
    .vld_o(d2_v), .quo_o(d2_q), .side_o(d2_side)
  );

  // Stage 3: seek and flee results; arrive velocity error
  logic              p3_v_r;
  logic [2:0][47:0]  p3_num_r;
  p3_t               p3_side_r;
  logic [2:0][47:0]  p3_num_nxt;
  p3_t               p3_side_nxt;
  logic signed [32:0] qs1, des1;
  logic signed [31:0] ms1;
  logic signed [33:0] err, abse;

  always_comb begin
    p3_num_nxt = '0;
    p3_side_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      qs1  = $signed({2'b00, d2_q[i]});
      des1 = d2_side.lenz ? 33'sd0 : (d2_side.neg[i] ? -qs1 : qs1);
      ms1  = $signed({1'b0, d2_side.mag[i]});
      err  = 34'(des1) - 34'($signed(d2_side.vel[i]));
      abse = err[33] ? -err : err;
      p3_num_nxt[i]       = {abse[31:0], {FRAC_W{1'b0}}};
      p3_side_nxt.nege[i] = err[33];
      unique case (mode_r)
        MODE_SEEK: p3_side_nxt.res[i] = d2_side.clamp ? 32'(des1)
                                                      : (d2_side.neg[i] ? -ms1 : ms1);
        MODE_FLEE: p3_side_nxt.res[i] = 32'(des1);
        MODE_ARRIVE, MODE_NONE: p3_side_nxt.res[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (en) begin
      p3_v_r <= d2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_num_r  <= p3_num_nxt;
      p3_side_r <= p3_side_nxt;
    end
  end

  // Attenuation divide; a zero divisor counts as one LSB
  logic [CFG_W-1:0] attn_div;
  assign attn_div = (attn_r == '0) ? CFG_W'(1) : attn_r;

  logic              d3_v;
  logic [2:0][47:0]  d3_q;
  p3_t               d3_side;

  sasf_udiv #(.LANES(3), .NW(48), .DW(CFG_W), .QW(48), .SW($bits(p3_t))) u_div_attn (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(p3_v_r), .num_i(p3_num_r), .den_i(attn_div), .side_i(p3_side_r),
    .vld_o(d3_v), .quo_o(d3_q), .side_o(d3_side)
  );

  // Stage 4: signed attenuated error
  logic                    p4_v_r;
  logic [2:0][48:0]        p4_w_r;
  logic [2:0][COMP_W-1:0]  p4_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_v_r <= 1'b0;
    end else if (en) begin
      p4_v_r <= d3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p4_w_r[i] <= d3_side.nege[i] ? -$signed({1'b0, d3_q[i]}) : $signed({1'b0, d3_q[i]});
      end
      p4_res_r <= d3_side.res;
    end
  end

  // Second length, for the arrive clamp
  logic                   l2_v;
  logic [2:0][MAG_W-1:0]  l2_mag;
  logic [2:0]             l2_neg;
  logic                   l2_sc;
  logic [SUMSQ_W-1:0]     l2_sumsq;
  logic [LEN_W-1:0]       l2_len;
  logic [2:0][COMP_W-1:0] l2_res;

  sasf_vlen #(.VW(49), .SW(3*COMP_W)) u_len2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(p4_v_r), .vec_i(p4_w_r), .side_i(p4_res_r),
    .vld_o(l2_v), .mag_o(l2_mag), .neg_o(l2_neg), .scaled_o(l2_sc),
    .sumsq_o(l2_sumsq), .len_o(l2_len), .side_o(l2_res)
  );

  // Stage 5: clamp numerators
  logic              p5_v_r;
  logic [2:0][61:0]  p5_num_r;
  logic [LEN_W-1:0]  p5_den_r;
  p5_t               p5_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p5_v_r <= 1'b0;
    end else if (en) begin
      p5_v_r <= l2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) p5_num_r[i] <= 62'(l2_mag[i]) * 62'(max_accel_r);
      p5_den_r        <= l2_len;
      p5_side_r.mag   <= l2_mag;
      p5_side_r.neg   <= l2_neg;
      p5_side_r.clamp <= l2_sc || (l2_sumsq > SUMSQ_W'(ma_sq_r));
      p5_side_r.lenz  <= (l2_len == '0);
      p5_side_r.res   <= l2_res;
    end
  end

  logic                  d4_v;
  logic [2:0][MAG_W-1:0] d4_q;
  p5_t                   d4_side;

  sasf_udiv #(.LANES(3), .NW(62), .DW(LEN_W), .QW(MAG_W), .SW($bits(p5_t))) u_div_rescale2 (
    .clk(clk), .rst_n(rst_n), .en(en),
    .vld_i(p5_v_r), .num_i(p5_num_r), .den_i(p5_den_r), .side_i(p5_side_r),
    .vld_o(d4_v), .quo_o(d4_q), .side_o(d4_side)
  );

  // Output register: pick the result for the mode; values already fit 32 bits
  logic [95:0]        out_data_r;
  logic [95:0]        out_data_nxt;
  logic signed [31:0] qs4, ms4, arr;

  always_comb begin
    out_data_nxt = '0;
    for (int i = 0; i < 3; i++) begin
      qs4 = $signed({1'b0, d4_q[i]});
      ms4 = $signed({1'b0, d4_side.mag[i]});
      if (d4_side.clamp) begin
        arr = d4_side.lenz ? 32'sd0 : (d4_side.neg[i] ? -qs4 : qs4);
      end else begin
        arr = d4_side.neg[i] ? -ms4 : ms4;
      end
      unique case (mode_r)
        MODE_ARRIVE:          out_data_nxt[32*i +: 32] = arr;
        MODE_SEEK, MODE_FLEE: out_data_nxt[32*i +: 32] = d4_side.res[i];
        MODE_NONE:            out_data_nxt[32*i +: 32] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // A held output freezes the pipeline ends
  `SASF_ASSERT_NEXT(a_hold_head, clk, rst_n, !in_tready, $stable(p0_v_r))
  `SASF_ASSERT_NEXT(a_hold_tail, clk, rst_n, !in_tready, $stable(d4_v) && $stable(out_data_r))

endmodule
